FILE: design/huffman_code_bit_packer_top_macros.svh
// Assertion macros for the Huffman code bit packer.
`ifndef HUFFMAN_CODE_BIT_PACKER_TOP_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HCBP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HCBP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/hcbp_pkg.sv
// Shared constants and types of the Huffman code bit packer.
package hcbp_pkg;

   // Configuration of the coder
   localparam int MAX_CODE_LEN  = 32;
   localparam int ALPHABET_SIZE = 256;

   // Fixed field widths
   localparam int FUNC_W = 2;
   localparam int SYM_W  = 8;
   localparam int CODE_W = 32;
   localparam int LEN_W  = 6;
   localparam int BYTE_W = 8;
   localparam int VB_W   = 4;
   localparam int PEND_W = BYTE_W - 1;

   // Derived sizes
   localparam int CLAMP_LEN = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int ACC_W     = CLAMP_LEN + PEND_W;
   localparam int CNT_W     = $clog2(ACC_W + 1);
   localparam int TBL_AW    = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

   // Function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

   // One code table word: clamped length and masked code bits
   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } tbl_entry_type;

   // Item waiting for its table read
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              in_alpha;
   } stage_type;

endpackage

FILE: design/hcbp_intf.sv
// Request and response channel interfaces of the Huffman code bit packer.
interface hcbp_req_if;
   logic                             valid;
   logic                             ready;
   logic [hcbp_pkg::FUNC_W-1:0]      func;
   logic [hcbp_pkg::SYM_W-1:0]       symbol;
   logic [hcbp_pkg::CODE_W-1:0]      code_value;
   logic [hcbp_pkg::LEN_W-1:0]       code_length;

   modport source (output valid, func, symbol, code_value, code_length, input ready);
   modport sink   (input valid, func, symbol, code_value, code_length, output ready);
endinterface

interface hcbp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [hcbp_pkg::BYTE_W-1:0]      packed_byte;
   logic [hcbp_pkg::VB_W-1:0]        valid_bits;
   logic                             last_of_run;

   modport source (output valid, packed_byte, valid_bits, last_of_run, input ready);
   modport sink   (input valid, packed_byte, valid_bits, last_of_run, output ready);
endinterface

FILE: design/hcbp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/huffman_code_bit_packer_top.sv
// Huffman code bit packer: code table RAM, bit accumulator and byte output stage.
//
// Usage:
//  - req channel (valid/ready): func selects load (write code table entry
//    symbol with code_value/code_length), encode (append the code of symbol)
//    or flush (emit leftover bits zero-padded). Other func codes do nothing.
//  - rsp channel (valid/ready): one packed byte per transfer, earliest bit in
//    the MSB; valid_bits is 8, or 1..7 for a flushed tail; last_of_run marks
//    the final byte of the request that caused it.
//  - Code table entries must be loaded before they are encoded.
//  - Path: an encoded byte passes the lookup stage register, the accumulator
//    and the output register; a flushed tail goes from the lookup stage register straight to the output register.
//  - Throughput: full bytes (up to four for a 32-bit code) leave the
//    output register at one byte per cycle while the receiver is ready;
//    new requests wait while the bytes drain. The table is read in the cycle of
//    the transfer, so loads and encodes follow each other back to back.
//  - Reset (synchronous, active high) clears the leftover bits and all
//    handshake state; the code table keeps its contents.
//  - A stalled receiver holds the output byte; the accumulator then fills,
//    and req.ready drops once the item behind it cannot advance.
`include "huffman_code_bit_packer_top_macros.svh"

module huffman_code_bit_packer_top (
   input  logic           clock,
   input  logic           reset,
   hcbp_req_if.sink       req,
   hcbp_rsp_if.source     rsp
);

   localparam int ENTRY_W = $bits(hcbp_pkg::tbl_entry_type);

   // Request side
   logic                              req_xfer;
   logic                              req_in_alpha;
   logic [hcbp_pkg::LEN_W-1:0]        ld_len;
   logic [hcbp_pkg::CODE_W:0]         ld_mask;
   logic                              tbl_wr_en;
   hcbp_pkg::tbl_entry_type           tbl_wr;
   logic [ENTRY_W-1:0]                tbl_rd_raw;
   hcbp_pkg::tbl_entry_type           tbl_rd;

   // Lookup stage
   logic                              s1_valid_ff, s1_valid_in;
   hcbp_pkg::stage_type               s1_ff, s1_in;
   logic                              s1_take;
   logic                              s1_is_enc;
   logic                              s1_is_flush;

   // Accumulator
   logic [hcbp_pkg::ACC_W-1:0]        acc_ff, acc_in;
   logic [hcbp_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic                              busy;
   logic [2:0]                        cnt3;
   logic [hcbp_pkg::PEND_W-1:0]       pend;
   logic                              flush_emit;
   logic [hcbp_pkg::CNT_W-1:0]        sh;
   logic [hcbp_pkg::VB_W-1:0]         fl_sh;

   // Output register
   logic                              out_valid_ff, out_valid_in;
   logic [hcbp_pkg::BYTE_W-1:0]       out_byte_ff, out_byte_in;
   logic [hcbp_pkg::VB_W-1:0]         out_vb_ff, out_vb_in;
   logic                              out_last_ff, out_last_in;
   logic                              out_free;

   // Check terms
   logic                              cnt_ok;
   logic                              drain_now;
   logic                              out_partial;

   // Request transfer and table write
   assign req_xfer     = req.valid && req.ready;
   assign req_in_alpha = int'(req.symbol) < hcbp_pkg::ALPHABET_SIZE;
   assign ld_len       = (int'(req.code_length) > hcbp_pkg::CLAMP_LEN) ?
                         hcbp_pkg::LEN_W'(hcbp_pkg::CLAMP_LEN) : req.code_length;
   assign ld_mask      = ~({(hcbp_pkg::CODE_W + 1){1'b1}} << ld_len);
   assign tbl_wr_en    = req_xfer && (req.func == hcbp_pkg::FUNC_LOAD) && req_in_alpha;
   assign tbl_wr.len   = ld_len;
   assign tbl_wr.code  = req.code_value & ld_mask[hcbp_pkg::CODE_W-1:0];

   hcbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (hcbp_pkg::ALPHABET_SIZE)
   ) u_code_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (req.symbol[hcbp_pkg::TBL_AW-1:0]),
      .wr_data (tbl_wr),
      .rd_en   (req_xfer),
      .rd_addr (req.symbol[hcbp_pkg::TBL_AW-1:0]),
      .rd_data (tbl_rd_raw)
   );

   assign tbl_rd = hcbp_pkg::tbl_entry_type'(tbl_rd_raw);

   // Accumulator status
   assign busy     = cnt_ff >= hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W);
   assign cnt3     = cnt_ff[2:0];
   assign pend     = acc_ff[hcbp_pkg::PEND_W-1:0] & ~({hcbp_pkg::PEND_W{1'b1}} << cnt3);
   assign sh       = cnt_ff - hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W);
   assign fl_sh    = hcbp_pkg::VB_W'(hcbp_pkg::BYTE_W) - {1'b0, cnt3};
   assign out_free = !out_valid_ff || rsp.ready;

   // Lookup stage advance
   assign s1_is_enc   = s1_ff.func == hcbp_pkg::FUNC_ENCODE;
   assign s1_is_flush = s1_ff.func == hcbp_pkg::FUNC_FLUSH;
   assign flush_emit  = s1_is_flush && (cnt3 != 3'd0);
   assign s1_take     = s1_valid_ff && !busy && (!flush_emit || out_free);
   assign req.ready   = !s1_valid_ff || s1_take;

   always_comb begin
      s1_in.func     = req.func;
      s1_in.in_alpha = req_in_alpha;
      s1_valid_in    = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_take) begin
         s1_valid_in = 1'b0;
         s1_in       = s1_ff;
      end else begin
         s1_in       = s1_ff;
      end
   end

   // Merge, drain and flush
   always_comb begin
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_byte_in  = out_byte_ff;
      out_vb_in    = out_vb_ff;
      out_last_in  = out_last_ff;
      if (busy) begin
         if (out_free) begin
            out_valid_in = 1'b1;
            out_byte_in  = hcbp_pkg::BYTE_W'(acc_ff >> sh);
            out_vb_in    = hcbp_pkg::VB_W'(hcbp_pkg::BYTE_W);
            out_last_in  = sh < hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W);
            cnt_in       = sh;
         end
      end else if (s1_take) begin
         if (s1_is_enc) begin
            if (s1_ff.in_alpha) begin
               acc_in = (hcbp_pkg::ACC_W'(pend) << tbl_rd.len) |
                        hcbp_pkg::ACC_W'(tbl_rd.code);
               cnt_in = cnt_ff + hcbp_pkg::CNT_W'(tbl_rd.len);
            end else begin
               acc_in = hcbp_pkg::ACC_W'(pend);
            end
         end else if (s1_is_flush) begin
            cnt_in = '0;
            if (flush_emit) begin
               out_valid_in = 1'b1;
               out_byte_in  = hcbp_pkg::BYTE_W'({1'b0, pend} << fl_sh);
               out_vb_in    = {1'b0, cnt3};
               out_last_in  = 1'b1;
            end
         end
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         cnt_ff       <= '0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
      s1_ff       <= s1_in;
      out_byte_ff <= out_byte_in;
      out_vb_ff   <= out_vb_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.packed_byte = out_byte_ff;
   assign rsp.valid_bits  = out_vb_ff;
   assign rsp.last_of_run = out_last_ff;

   // Checks
   assign cnt_ok      = int'(cnt_ff) <= hcbp_pkg::ACC_W;
   assign drain_now   = busy && out_free;
   assign out_partial = out_valid_ff && (out_vb_ff != hcbp_pkg::VB_W'(hcbp_pkg::BYTE_W));

   `HCBP_ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1, cnt_ok, "count out of range")
   `HCBP_ASSERT_NEXT(a_drain_step, clock, reset, drain_now, cnt_ff == $past(sh), "bad drain step")
   `HCBP_ASSERT_IMPL(a_tail_last, clock, reset, out_partial, out_last_ff, "partial byte not last")
   `HCBP_ASSERT_IMPL(a_hold_stage, clock, reset, s1_valid_ff && busy, !req.ready, "stage overrun")

endmodule
